FILE: rtl/four_digit_seven_segment_scanner_assert.svh
// Assertion macros used by the display scanner checker.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FDSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FDSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fdss_pkg.sv
// Types, constants and the segment table of the display scanner.
package fdss_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [9:0] VALUE_MAX = 10'd1000;
  localparam logic [7:0] SEG_DP    = 8'h80;

  typedef logic [3:0][7:0] pattern_set_t;

  // Patterns of 100.0: digit 0 is the thousands place, digit 2 carries the point.
  localparam pattern_set_t RESET_PATTERNS = {8'h3F, 8'hBF, 8'h3F, 8'h06};

  typedef struct packed {
    logic        cmd;
    logic [15:0] value_tenths;
    logic        blank_request;
  } in_item_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [7:0] segments_n;
    logic [1:0] digit_index;
  } out_item_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/fdss_pattern.sv
// Splits the shown value into decimal digits and maps them to segment patterns.
module fdss_pattern (
  input  logic [9:0]            value,
  input  logic                  blank,
  output fdss_pkg::pattern_set_t patterns
);

  logic        thousands;
  logic [9:0]  rest;
  logic [15:0] hund_prod;
  logic [3:0]  hundreds;
  logic [9:0]  hund_sub;
  logic [6:0]  rest2;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_sub;
  logic [3:0]  ones;

  // The value never exceeds 1000, so the thousands place is a single compare.
  assign thousands = (value >= fdss_pkg::VALUE_MAX);
  assign rest      = thousands ? (value - fdss_pkg::VALUE_MAX) : value;

  // Division by 100 as a multiply by 41/4096, exact for values below 1000.
  assign hund_prod = {6'd0, rest} * 16'd41;
  assign hundreds  = hund_prod[15:12];
  assign hund_sub  = {6'd0, hundreds} * 10'd100;
  assign rest2     = 7'(rest - hund_sub);

  // Division by 10 as a multiply by 205/2048, exact for values below 100.
  assign tens_prod = {8'd0, rest2} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_sub  = {3'd0, tens} * 7'd10;
  assign ones      = 4'(rest2 - tens_sub);

  always_comb begin
    if (blank) begin
      patterns = '0;
    end else begin
      patterns[0] = fdss_pkg::seg_code({3'd0, thousands});
      patterns[1] = fdss_pkg::seg_code(hundreds);
      patterns[2] = fdss_pkg::seg_code(tens) | fdss_pkg::SEG_DP;
      patterns[3] = fdss_pkg::seg_code(ones);
    end
  end

endmodule

FILE: rtl/fdss_core.sv
// Display state: stored value, blanking, frame patterns and scan position.
module fdss_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  fdss_pkg::in_item_t  item,
  output logic                result_valid,
  output fdss_pkg::out_item_t result
);

  logic [9:0]             shown_value;
  logic                   blank_mode;
  fdss_pkg::pattern_set_t digit_patterns;
  logic [1:0]             scan_position;

  fdss_pkg::pattern_set_t built;
  logic [7:0]             pattern_sel;
  logic [9:0]             clamped;

  fdss_pattern u_pattern (
    .value    (shown_value),
    .blank    (blank_mode),
    .patterns (built)
  );

  assign clamped = (item.value_tenths > {6'd0, fdss_pkg::VALUE_MAX}) ?
                   fdss_pkg::VALUE_MAX : item.value_tenths[9:0];

  // At the start of a frame the fresh patterns are shown directly.
  assign pattern_sel = (scan_position == 2'd0) ? built[0] : digit_patterns[scan_position];

  assign result_valid        = item_valid && (item.cmd == fdss_pkg::CMD_TICK);
  assign result.digit_enable = 4'b0001 << scan_position;
  assign result.segments_n   = ~pattern_sel;
  assign result.digit_index  = scan_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_value    <= fdss_pkg::VALUE_MAX;
      blank_mode     <= 1'b0;
      digit_patterns <= fdss_pkg::RESET_PATTERNS;
      scan_position  <= 2'd0;
    end else if (item_valid) begin
      if (item.cmd == fdss_pkg::CMD_SET) begin
        if (item.blank_request) begin
          blank_mode <= 1'b1;
        end else begin
          blank_mode  <= 1'b0;
          shown_value <= clamped;
        end
      end else begin
        if (scan_position == 2'd0) begin
          digit_patterns <= built;
        end
        scan_position <= scan_position + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/four_digit_seven_segment_scanner.sv
// Top level of the multiplexed four-digit seven-segment display scanner.
// A tick request waits in the input register until it can advance, and its result is
// then registered in the output register, where it is held until it is taken.
// Throughput: one request per cycle while the output is not stalled; set requests pass through without a result.
// Reset: value 1000 shown as 100.0, blanking off, scan position 0, both
// the input and output registers empty.
module four_digit_seven_segment_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fdss_pkg::out_item_t out_data
);

  fdss_pkg::in_item_t  in_q;
  logic                in_q_valid;
  logic                advance;
  logic                result_valid;
  fdss_pkg::out_item_t result;

  // A set request never needs the output register, so it always moves on.
  assign advance  = in_q_valid &&
                    ((in_q.cmd == fdss_pkg::CMD_SET) || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  fdss_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (advance),
    .item         (in_q),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/fdss_checker.sv
// Port-level checks of the display scanner and their binding to the top level.
`include "four_digit_seven_segment_scanner_assert.svh"

module fdss_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fdss_pkg::out_item_t out_data
);

  logic enable_onehot;
  logic enable_match;
  logic out_stalled;

  assign enable_onehot = $onehot(out_data.digit_enable);
  assign enable_match  = (out_data.digit_enable == (4'b0001 << out_data.digit_index));
  assign out_stalled   = out_valid && !out_ready;

  `FDSS_ASSERT_NOW(a_enable_onehot, clk, rst, out_valid, enable_onehot, "enable not one-hot")
  `FDSS_ASSERT_NOW(a_enable_matches_index, clk, rst, out_valid, enable_match, "enable mismatch")
  `FDSS_ASSERT_NOW(a_stall_only_on_output, clk, rst, !in_ready, out_stalled, "needless stall")
  `FDSS_ASSERT_NEXT(a_result_holds, clk, rst, out_stalled, out_valid && $stable(out_data), "lost")

endmodule

bind four_digit_seven_segment_scanner fdss_checker u_fdss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
